// ===== sv/box_view_cone_cull_macros.svh =====
// Assertion macros shared by the checker of box_view_cone_cull.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BOX_VIEW_CONE_CULL_MACROS_SVH
`define BOX_VIEW_CONE_CULL_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BVCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bvcc check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define BVCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bvcc check failed one cycle later");

`endif

// ===== sv/bvcc_pkg.sv =====
package bvcc_pkg;

    // Field widths of items and registers.
    localparam int COORD_W = 32;
    localparam int HALF_W  = 31;
    localparam int HEAD_W  = 16;
    localparam int LOOK_W  = 18;

    // Stream bus widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 208;
    localparam int OUT_TDATA_W = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_EYE_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EYE_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EYE_Z       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOK_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOK_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOK_Z      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CONE_COSINE = 3'd6;

    // Point and cone test widths.
    localparam int PT_W    = 35;
    localparam int DOT_W   = 54;
    localparam int SQ_W    = 70;
    localparam int CMP_W   = 108;
    localparam int LANE_LAT = 8;
    localparam int POINT_COUNT = 9;

    // CORDIC sine and cosine in Q4.30.
    localparam int CORDIC_STEPS    = 30;
    localparam int STEPS_PER_STAGE = 3;
    localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
    localparam int CORDIC_W        = 34;
    localparam int ANGLE_W         = 33;
    localparam int CORDIC_FRAC     = 30;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [31:0] ARC_TABLE [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
        32'd20, 32'd10, 32'd5, 32'd3, 32'd1
    };

    // View settings as seen by every cone test lane.
    typedef struct packed {
        logic signed [COORD_W-1:0] eye_x;
        logic signed [COORD_W-1:0] eye_y;
        logic signed [COORD_W-1:0] eye_z;
        logic signed [LOOK_W-1:0]  look_x;
        logic signed [LOOK_W-1:0]  look_y;
        logic signed [LOOK_W-1:0]  look_z;
        logic signed [LOOK_W-1:0]  cone_cosine;
    } view_cfg_t;

    // One point to be tested against the cone.
    typedef struct packed {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic signed [PT_W-1:0] z;
    } point_t;

endpackage

// ===== sv/bvcc_point_test.sv =====
module bvcc_point_test (
    input  logic                clk,
    input  logic                en,
    input  bvcc_pkg::view_cfg_t cfg,
    input  bvcc_pkg::point_t    pt,
    output logic                hit
);
    import bvcc_pkg::*;

    localparam int PROD_W = PT_W + LOOK_W;
    localparam int MAG_W  = DOT_W - 1;
    localparam int LO_W   = 27;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int D2H_W  = SQ_W / 2;
    localparam int T_W    = SQ_W + LOOK_W;
    localparam int TC_W   = 30;

    // Cone settings must not change while items are in flight; not enforced here.
    logic                    cone_neg;
    logic [LOOK_W-1:0]       cone_mag;

    // Stage 1: offset from the eye.
    logic signed [PT_W-1:0]   dx_reg, dy_reg, dz_reg;
    // Stage 2: dot product terms and squares.
    logic signed [PROD_W-1:0] mx_reg, my_reg, mz_reg;
    logic [SQ_W-1:0]          qx_reg, qy_reg, qz_reg;
    // Stage 3: dot product and squared distance.
    logic signed [DOT_W-1:0]  dot_reg;
    logic [SQ_W-1:0]          d2_reg;
    // Stage 4: partial products of both sides.
    logic [MAG_W-1:0]         dm_next;
    logic [2*HI_W-1:0]        hh_reg;
    logic [HI_W+LO_W-1:0]     hl_reg;
    logic [2*LO_W-1:0]        ll_reg;
    logic [D2H_W+LOOK_W-1:0]  dl_reg, dh_reg;
    logic                     neg4_reg;
    // Stage 5: left side and distance times cone magnitude.
    logic [CMP_W-1:0]         lhs5_reg;
    logic [T_W-1:0]           t_reg;
    logic                     neg5_reg;
    // Stage 6: partial products of the right side.
    logic [CMP_W-1:0]         lhs6_reg;
    logic [TC_W+LOOK_W-1:0]   r0_reg, r1_reg;
    logic [T_W-2*TC_W+LOOK_W-1:0] r2_reg;
    logic                     neg6_reg;
    // Stage 7: both sides complete.
    logic [CMP_W-1:0]         lhs7_reg, rhs7_reg;
    logic                     neg7_reg;
    // Stage 8: decision.
    logic                     inside_reg;

    assign cone_neg = cfg.cone_cosine[LOOK_W-1];
    assign cone_mag = cone_neg ? LOOK_W'(-cfg.cone_cosine) : LOOK_W'(cfg.cone_cosine);

    // Stage 1: subtract the eye position.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= pt.x - PT_W'(cfg.eye_x);
            dy_reg <= pt.y - PT_W'(cfg.eye_y);
            dz_reg <= pt.z - PT_W'(cfg.eye_z);
        end
    end

    // Stage 2: multiply by the view direction and square each offset.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg <= PROD_W'(dx_reg * $signed(cfg.look_x));
            my_reg <= PROD_W'(dy_reg * $signed(cfg.look_y));
            mz_reg <= PROD_W'(dz_reg * $signed(cfg.look_z));
            qx_reg <= SQ_W'(dx_reg * dx_reg);
            qy_reg <= SQ_W'(dy_reg * dy_reg);
            qz_reg <= SQ_W'(dz_reg * dz_reg);
        end
    end

    // Stage 3: sum the terms.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot_reg <= DOT_W'(mx_reg) + DOT_W'(my_reg) + DOT_W'(mz_reg);
            d2_reg  <= qx_reg + qy_reg + qz_reg;
        end
    end

    // Stage 4: split the wide squares into narrow partial products.
    assign dm_next = dot_reg[DOT_W-1] ? MAG_W'(-dot_reg) : MAG_W'(dot_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg   <= (2*HI_W)'(dm_next[MAG_W-1:LO_W] * dm_next[MAG_W-1:LO_W]);
            hl_reg   <= (HI_W+LO_W)'(dm_next[MAG_W-1:LO_W] * dm_next[LO_W-1:0]);
            ll_reg   <= (2*LO_W)'(dm_next[LO_W-1:0] * dm_next[LO_W-1:0]);
            dl_reg   <= (D2H_W+LOOK_W)'(d2_reg[D2H_W-1:0] * cone_mag);
            dh_reg   <= (D2H_W+LOOK_W)'(d2_reg[SQ_W-1:D2H_W] * cone_mag);
            neg4_reg <= dot_reg[DOT_W-1];
        end
    end

    // Stage 5: assemble the squared dot product and the first cone product.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lhs5_reg <= (CMP_W'(hh_reg) << (2*LO_W)) + (CMP_W'(hl_reg) << (LO_W+1))
                        + CMP_W'(ll_reg);
            t_reg    <= (T_W'(dh_reg) << D2H_W) + T_W'(dl_reg);
            neg5_reg <= neg4_reg;
        end
    end

    // Stage 6: second cone product in three slices.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lhs6_reg <= lhs5_reg;
            r0_reg   <= (TC_W+LOOK_W)'(t_reg[TC_W-1:0] * cone_mag);
            r1_reg   <= (TC_W+LOOK_W)'(t_reg[2*TC_W-1:TC_W] * cone_mag);
            r2_reg   <= (T_W-2*TC_W+LOOK_W)'(t_reg[T_W-1:2*TC_W] * cone_mag);
            neg6_reg <= neg5_reg;
        end
    end

    // Stage 7: assemble the right side.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lhs7_reg <= lhs6_reg;
            rhs7_reg <= (CMP_W'(r2_reg) << (2*TC_W)) + (CMP_W'(r1_reg) << TC_W)
                        + CMP_W'(r0_reg);
            neg7_reg <= neg6_reg;
        end
    end

    // Stage 8: signed comparison of the squares.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (cone_neg)
                inside_reg <= !neg7_reg || (lhs7_reg <= rhs7_reg);
            else
                inside_reg <= !neg7_reg && (lhs7_reg >= rhs7_reg);
        end
    end

    assign hit = inside_reg;

endmodule

// ===== sv/box_view_cone_cull.sv =====
// Box view cone culling.
// Input stream s_*: one box per item (center, half extents, heading). Output
// stream m_*: one item per box, bit 0 of m_tdata is 1 when the center or any
// of the eight corners lies inside the view cone.
// The cfg_* port writes the eye position, view direction and cone cosine; the
// user writes it only while no box is in flight, and the block does not enforce it.
// An item passes 24 register stages: one input stage, ten CORDIC stages of
// three steps each, four stages that build the corners, eight stages of the
// cone test lanes and one output stage. The first stage loads at the accepting
// edge.
// Throughput is one box per cycle while the receiver does not stall; all stages advance together on one enable.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops in the same cycle; nothing is lost or repeated.
// Reset empties the pipeline and loads eye (0,0,0), look (1,0,0) and a cone
// cosine of 0.
module box_view_cone_cull #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // center_x, center_y, center_z, half_x, half_y, half_z, heading, zero pad
    input  logic [bvcc_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // visible, zero pad
    output logic [bvcc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [bvcc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bvcc_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);
    import bvcc_pkg::*;

    localparam int CS_W   = FRAC_BITS + 3;
    localparam int PR_W   = COORD_W + CS_W;
    localparam int RND_SH = CORDIC_FRAC - FRAC_BITS;
    localparam int BOX_STAGES = CORDIC_STAGES + 4;
    localparam int NST    = BOX_STAGES + 1 + LANE_LAT + 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [HALF_W-1:0]         hx;
        logic [HALF_W-1:0]         hy;
        logic [HALF_W-1:0]         hz;
    } box_t;

    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 33'sd1073741824;
    localparam logic signed [ANGLE_W-1:0] HALF_TURN    = 33'sd2147483648;

    logic                          en;
    logic [NST-1:0]                v_reg;
    view_cfg_t                     cfg_reg, cfg_next;
    box_t                          box_reg [0:BOX_STAGES-1];
    box_t                          box_next;
    logic signed [CORDIC_W-1:0]    x_reg [0:CORDIC_STAGES];
    logic signed [CORDIC_W-1:0]    y_reg [0:CORDIC_STAGES];
    logic signed [ANGLE_W-1:0]     z_reg [0:CORDIC_STAGES];
    logic                          flip_reg [0:CORDIC_STAGES];
    logic signed [ANGLE_W-1:0]     z_raw, z_next;
    logic                          flip_next;
    logic signed [CORDIC_W-1:0]    xf, yf;
    logic signed [CS_W-1:0]        cos_reg, sin_reg;
    logic signed [PR_W-1:0]        p0x_reg, p0y_reg, p1x_reg, p1y_reg;
    logic signed [PT_W-1:0]        s0x_reg, s0y_reg, s1x_reg, s1y_reg;
    point_t                        pt_reg [0:POINT_COUNT-1];
    logic [POINT_COUNT-1:0]        inside_w;
    logic                          vis_reg;

    // The whole pipeline advances unless a result waits on a stalled receiver.
    assign en       = !v_reg[NST-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = v_reg[NST-1];
    assign m_tdata  = {{(OUT_TDATA_W-1){1'b0}}, vis_reg};

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NST-2:0], s_tvalid};
    end

    // Configuration registers.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_EYE_X:       cfg_next.eye_x = cfg_wr_data;
                CFG_EYE_Y:       cfg_next.eye_y = cfg_wr_data;
                CFG_EYE_Z:       cfg_next.eye_z = cfg_wr_data;
                CFG_LOOK_X:      cfg_next.look_x = cfg_wr_data[LOOK_W-1:0];
                CFG_LOOK_Y:      cfg_next.look_y = cfg_wr_data[LOOK_W-1:0];
                CFG_LOOK_Z:      cfg_next.look_z = cfg_wr_data[LOOK_W-1:0];
                CFG_CONE_COSINE: cfg_next.cone_cosine = cfg_wr_data[LOOK_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.eye_x       <= '0;
            cfg_reg.eye_y       <= '0;
            cfg_reg.eye_z       <= '0;
            cfg_reg.look_x      <= 18'sd65536;
            cfg_reg.look_y      <= '0;
            cfg_reg.look_z      <= '0;
            cfg_reg.cone_cosine <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Input stage: unpack the item and fold the heading into a half turn.
    always_comb
    begin
        box_next.cx = s_tdata[31:0];
        box_next.cy = s_tdata[63:32];
        box_next.cz = s_tdata[95:64];
        box_next.hx = s_tdata[126:96];
        box_next.hy = s_tdata[157:127];
        box_next.hz = s_tdata[188:158];
        z_raw = ANGLE_W'($signed({s_tdata[204:189], 16'b0}));
        z_next    = z_raw;
        flip_next = 1'b0;
        if (z_raw > QUARTER_TURN)
        begin
            z_next    = z_raw - HALF_TURN;
            flip_next = 1'b1;
        end
        else if (z_raw < -QUARTER_TURN)
        begin
            z_next    = z_raw + HALF_TURN;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            box_reg[0]  <= box_next;
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_next;
            flip_reg[0] <= flip_next;
        end
    end

    // Box fields ride along with the angle work.
    for (genvar b = 1; b < BOX_STAGES; b++)
    begin : g_box
        always_ff @(posedge clk)
        begin
            if (en)
                box_reg[b] <= box_reg[b-1];
        end
    end

    // CORDIC rotation, three steps per stage.
    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cordic
        logic signed [CORDIC_W-1:0] x_n, y_n;
        logic signed [ANGLE_W-1:0]  z_n;

        always_comb
        begin
            logic signed [CORDIC_W-1:0] xt;
            x_n = x_reg[g];
            y_n = y_reg[g];
            z_n = z_reg[g];
            for (int j = 0; j < STEPS_PER_STAGE; j++)
            begin
                if (!z_n[ANGLE_W-1])
                begin
                    xt  = x_n - (y_n >>> (g*STEPS_PER_STAGE + j));
                    y_n = y_n + (x_n >>> (g*STEPS_PER_STAGE + j));
                    z_n = z_n - $signed({1'b0, ARC_TABLE[g*STEPS_PER_STAGE + j]});
                end
                else
                begin
                    xt  = x_n + (y_n >>> (g*STEPS_PER_STAGE + j));
                    y_n = y_n - (x_n >>> (g*STEPS_PER_STAGE + j));
                    z_n = z_n + $signed({1'b0, ARC_TABLE[g*STEPS_PER_STAGE + j]});
                end
                x_n = xt;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[g+1]    <= x_n;
                y_reg[g+1]    <= y_n;
                z_reg[g+1]    <= z_n;
                flip_reg[g+1] <= flip_reg[g];
            end
        end
    end

    // Undo the half turn fold and round to the working fraction.
    assign xf = flip_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];
    assign yf = flip_reg[CORDIC_STAGES] ? -y_reg[CORDIC_STAGES] : y_reg[CORDIC_STAGES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= CS_W'((xf + (CORDIC_W'(1) <<< (RND_SH-1))) >>> RND_SH);
            sin_reg <= CS_W'((yf + (CORDIC_W'(1) <<< (RND_SH-1))) >>> RND_SH);
        end
    end

    // Half extents times sine and cosine.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0x_reg <= PR_W'($signed({1'b0, box_reg[CORDIC_STAGES+1].hx}) * cos_reg);
            p0y_reg <= PR_W'($signed({1'b0, box_reg[CORDIC_STAGES+1].hx}) * sin_reg);
            p1x_reg <= PR_W'($signed({1'b0, box_reg[CORDIC_STAGES+1].hy}) * sin_reg);
            p1y_reg <= PR_W'($signed({1'b0, box_reg[CORDIC_STAGES+1].hy}) * cos_reg);
        end
    end

    // Round the products, halves toward plus infinity.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0x_reg <= PT_W'((p0x_reg + (PR_W'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS);
            s0y_reg <= PT_W'((p0y_reg + (PR_W'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS);
            s1x_reg <= PT_W'((p1x_reg + (PR_W'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS);
            s1y_reg <= -PT_W'((p1y_reg + (PR_W'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS);
        end
    end

    // Build the center and the eight corners.
    for (genvar k = 0; k < POINT_COUNT; k++)
    begin : g_point
        localparam int  CI = (k + 3) % 4;
        localparam bit  SA = (CI == 1) || (CI == 2);
        localparam bit  SB = (CI >= 2);
        localparam bit  ZU = (k >= 5);
        point_t pt_next;

        always_comb
        begin
            pt_next.x = PT_W'(box_reg[BOX_STAGES-1].cx);
            pt_next.y = PT_W'(box_reg[BOX_STAGES-1].cy);
            pt_next.z = PT_W'(box_reg[BOX_STAGES-1].cz);
            if (k != 0)
            begin
                pt_next.x = pt_next.x + (SA ? s0x_reg : -s0x_reg)
                            + (SB ? s1x_reg : -s1x_reg);
                pt_next.y = pt_next.y + (SA ? s0y_reg : -s0y_reg)
                            + (SB ? s1y_reg : -s1y_reg);
                if (ZU)
                    pt_next.z = pt_next.z + $signed(PT_W'(box_reg[BOX_STAGES-1].hz));
                else
                    pt_next.z = pt_next.z - $signed(PT_W'(box_reg[BOX_STAGES-1].hz));
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                pt_reg[k] <= pt_next;
        end

        bvcc_point_test u_test (
            .clk (clk),
            .en  (en),
            .cfg (cfg_reg),
            .pt  (pt_reg[k]),
            .hit (inside_w[k])
        );
    end

    // Output register: visible when any point passes.
    always_ff @(posedge clk)
    begin
        if (en)
            vis_reg <= |inside_w;
    end

endmodule

// ===== sv/bvcc_checker.sv =====
`include "box_view_cone_cull_macros.svh"

module bvcc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [bvcc_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import bvcc_pkg::*;

    // A waiting result stays put until it is taken.
    `BVCC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Input is taken exactly when the output side can move.
    `BVCC_ASSERT_NOW(a_ready_follows_out, s_tvalid || !s_tvalid, s_tready == (!m_tvalid || m_tready))

    // Only the visible bit may be set in a result.
    `BVCC_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[OUT_TDATA_W-1:1] == '0)

endmodule

bind box_view_cone_cull bvcc_checker u_bvcc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
